// ===== sv/escaped_frame_receiver_crc8_assert.svh =====
// assertion macros for the escaped frame receiver checker
`ifndef ESCAPED_FRAME_RECEIVER_CRC8_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_CRC8_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define EFR_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("efr assertion failed: label");

// next-cycle implication, disabled while reset is held
`define EFR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("efr assertion failed: label");

`endif

// ===== sv/efr_pkg.sv =====
// shared types, codes and the crc-8 byte step of the escaped frame receiver
package efr_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_MASK  = 8'h20;
    localparam logic [7:0] CRC_GOOD  = 8'h00;
    localparam logic [7:0] CRC_POLY  = 8'h07;

    localparam logic [2:0] PH_HUNT     = 3'd0;
    localparam logic [2:0] PH_IDLE     = 3'd1;
    localparam logic [2:0] PH_IDLE_ESC = 3'd2;
    localparam logic [2:0] PH_MSG      = 3'd3;
    localparam logic [2:0] PH_MSG_ESC  = 3'd4;
    localparam logic [2:0] PH_END      = 3'd5;

    localparam logic [1:0] EV_START  = 2'd0;
    localparam logic [1:0] EV_BODY   = 2'd1;
    localparam logic [1:0] EV_COMMIT = 2'd2;
    localparam logic [1:0] EV_ABORT  = 2'd3;

    typedef struct packed {
        logic [2:0] phase;
        logic       address;
        logic [6:0] left;
        logic [7:0] crc;
    } t_rx_state;

    typedef struct packed {
        logic [1:0] kind;
        logic       address;
        logic [6:0] length;
        logic [7:0] data;
    } t_event;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/efr_step.sv =====
// next-state and event logic for one received byte
module efr_step #(
    parameter int ADDRESS_BITS = 1
) (
    input  efr_pkg::t_rx_state i_state,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_line_error,
    input  logic               i_sink_has_room,
    input  logic [1:0]         i_address_enable,
    output efr_pkg::t_rx_state o_state,
    output logic               o_has_event,
    output efr_pkg::t_event    o_event
);
    import efr_pkg::*;

    localparam int LEN_BITS = 8 - ADDRESS_BITS;

    logic [7:0]              unesc;
    logic [7:0]              hdr_src;
    logic [7:0]              body_src;
    logic [ADDRESS_BITS-1:0] hdr_addr;
    logic                    hdr_ok;
    logic [6:0]              hdr_len;
    logic [7:0]              hdr_crc;
    logic [7:0]              body_crc;
    logic                    is_flag;
    logic                    is_esc;

    assign unesc    = i_rx_byte ^ ESC_MASK;
    assign hdr_src  = (i_state.phase == PH_IDLE_ESC) ? unesc : i_rx_byte;
    assign body_src = (i_state.phase == PH_MSG_ESC) ? unesc : i_rx_byte;
    assign hdr_addr = hdr_src[7:LEN_BITS];
    assign hdr_ok   = ((hdr_addr >> 1) == '0) && i_address_enable[hdr_addr[0]]
                      && i_sink_has_room;
    assign hdr_len  = 7'(hdr_src[LEN_BITS-1:0]);
    assign hdr_crc  = crc8_step(8'h00, hdr_src);
    assign body_crc = crc8_step(i_state.crc, body_src);
    assign is_flag  = (i_rx_byte == FLAG_BYTE);
    assign is_esc   = (i_rx_byte == ESC_BYTE);

    always_comb begin
        o_state        = i_state;
        o_has_event    = 1'b0;
        o_event.kind   = EV_START;
        o_event.length = 7'd0;
        o_event.data   = 8'd0;
        case (i_state.phase)
            PH_IDLE, PH_IDLE_ESC: begin
                if (i_line_error || (i_state.phase == PH_IDLE_ESC && is_esc)) begin
                    o_state.phase = PH_HUNT;
                end else if (is_flag) begin
                    o_state.phase = PH_IDLE;
                end else if (i_state.phase == PH_IDLE && is_esc) begin
                    o_state.phase = PH_IDLE_ESC;
                end else if (!hdr_ok) begin
                    o_state.phase = PH_HUNT;
                end else begin
                    o_state.phase   = PH_MSG;
                    o_state.address = hdr_addr[0];
                    o_state.left    = hdr_len;
                    o_state.crc     = hdr_crc;
                    o_has_event     = 1'b1;
                    o_event.kind    = EV_START;
                    o_event.length  = hdr_len;
                end
            end
            PH_MSG, PH_MSG_ESC: begin
                if (i_line_error || (i_state.phase == PH_MSG_ESC && is_esc)) begin
                    o_state.phase = PH_HUNT;
                    o_has_event   = 1'b1;
                    o_event.kind  = EV_ABORT;
                end else if (is_flag) begin
                    o_state.phase = PH_IDLE;
                    o_has_event   = 1'b1;
                    o_event.kind  = EV_ABORT;
                end else if (i_state.phase == PH_MSG && is_esc) begin
                    o_state.phase = PH_MSG_ESC;
                end else begin
                    o_state.crc = body_crc;
                    if (i_state.left == 7'd0) begin
                        o_state.phase = PH_END;
                    end else begin
                        o_state.phase = PH_MSG;
                        o_state.left  = i_state.left - 7'd1;
                        o_has_event   = 1'b1;
                        o_event.kind  = EV_BODY;
                        o_event.data  = body_src;
                    end
                end
            end
            PH_END: begin
                o_has_event = 1'b1;
                if (i_line_error || !is_flag) begin
                    o_state.phase = PH_HUNT;
                    o_event.kind  = EV_ABORT;
                end else begin
                    o_state.phase = PH_IDLE;
                    o_event.kind  = (i_state.crc == CRC_GOOD) ? EV_COMMIT : EV_ABORT;
                end
            end
            default: begin
                o_state.phase = (!i_line_error && is_flag) ? PH_IDLE : PH_HUNT;
            end
        endcase
        o_event.address = o_state.address;
    end

endmodule

// ===== sv/escaped_frame_receiver_crc8.sv =====
// top level of the escaped frame receiver with crc-8 check
//
// usage:
//   input channel: one raw line byte per request with its line error flag
//   and the sink room flag, taken when i_in_valid is high and o_in_stall low.
//   output channel: one event per request (frame start, body byte, commit,
//   abort), taken when o_out_valid is high and i_out_stall low.
//   config channel: i_cfg_address_enable is written when i_cfg_valid and
//   o_cfg_ready are high; o_cfg_ready is always high. write only while idle.
// path: a taken byte goes into the input register, then the state update and
//   crc-8 step write its event into the output register.
// throughput: one byte per cycle unless the input stalls; the frame state and one
//   crc byte step are combinational, so bytes may arrive back to back.
// reset: the receiver hunts for a flag, all addresses are enabled and both
//   registers are empty.
// stall: a held event keeps its value; bytes that make no event still pass,
//   and the input stalls once a byte with an event finds the output full.
module escaped_frame_receiver_crc8 #(
    parameter int ADDRESS_BITS = 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_line_error,
    input  logic       i_sink_has_room,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_event_kind,
    output logic       o_frame_address,
    output logic [6:0] o_frame_length,
    output logic [7:0] o_body_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_address_enable
);
    import efr_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_error;
    logic       r_in_room;
    t_rx_state  r_state;
    logic [1:0] r_enable;
    logic       r_out_valid;
    t_event     r_out;

    t_rx_state  n_state;
    logic       has_event;
    t_event     n_out;
    logic       advance;
    logic       in_take;

    efr_step #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_step (
        .i_state         (r_state),
        .i_rx_byte       (r_in_byte),
        .i_line_error    (r_in_error),
        .i_sink_has_room (r_in_room),
        .i_address_enable(r_enable),
        .o_state         (n_state),
        .o_has_event     (has_event),
        .o_event         (n_out)
    );

    assign advance    = r_in_valid && (!has_event || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_rx_byte;
            r_in_error <= i_line_error;
            r_in_room  <= i_sink_has_room;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase   <= PH_HUNT;
            r_state.address <= 1'b0;
            r_state.left    <= 7'd0;
            r_state.crc     <= 8'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 2'b11;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_enable <= i_cfg_address_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (advance && has_event) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_event) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_out.kind;
    assign o_frame_address = r_out.address;
    assign o_frame_length  = r_out.length;
    assign o_body_data     = r_out.data;

endmodule

// ===== sv/efr_checker.sv =====
// port-level checker for the escaped frame receiver and its bind
`include "escaped_frame_receiver_crc8_assert.svh"

module efr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_event_kind,
    input logic       o_frame_address,
    input logic [6:0] o_frame_length,
    input logic [7:0] o_body_data
);
    import efr_pkg::*;

    // a held event keeps its whole payload
    `EFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_event_kind) && $stable(o_frame_address)
        && $stable(o_frame_length) && $stable(o_body_data))

    // only a frame start carries a length
    `EFR_ASSERT_NOW(a_len_only_start, i_clk, i_rst_n,
        o_out_valid && (o_event_kind != EV_START), o_frame_length == 7'd0)

    // only a body byte carries data
    `EFR_ASSERT_NOW(a_data_only_body, i_clk, i_rst_n,
        o_out_valid && (o_event_kind != EV_BODY), o_body_data == 8'd0)

endmodule

bind escaped_frame_receiver_crc8 efr_checker u_efr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_event_kind   (o_event_kind),
    .o_frame_address(o_frame_address),
    .o_frame_length (o_frame_length),
    .o_body_data    (o_body_data)
);

// ===== sim/tb_top.sv =====
// testbench for the escaped frame receiver: byte stream stimulus checked against a frame decoder
`timescale 1ns / 1ps

module tb_top;
    import efr_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int DRAIN_CYCLES    = 6;

    typedef enum int {
        FAULT_NONE, FAULT_LINE_ERR, FAULT_EARLY_FLAG, FAULT_BAD_CRC,
        FAULT_DOUBLE_ESC, FAULT_TRAILER, FAULT_NOISE
    } t_fault;

    typedef struct packed {
        logic [7:0] rx;
        logic       err;
        logic       room;
        logic       pinned;
        logic       pin_some;
        t_event     pin_ev;
    } t_line_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_line_error = 1'b0;
    logic       i_sink_has_room = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [1:0] o_event_kind;
    logic       o_frame_address;
    logic [6:0] o_frame_length;
    logic [7:0] o_body_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_address_enable = 2'b11;

    t_line_item drv_item = '0;
    t_line_item line_q[$];
    t_event     event_q[$];

    int send_idle_pct = 12;
    int recv_idle_pct = 62;
    int mismatches = 0;
    int cycle_count = 0;

    // decoder state
    logic [2:0] fr_phase = PH_HUNT;
    logic       fr_addr = 1'b0;
    logic [6:0] fr_left = 7'd0;
    logic [7:0] fr_crc = 8'h00;
    logic [1:0] fr_enable = 2'b11;

    escaped_frame_receiver_crc8 #(
        .ADDRESS_BITS(1)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_rx_byte           (i_rx_byte),
        .i_line_error        (i_line_error),
        .i_sink_has_room     (i_sink_has_room),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_event_kind        (o_event_kind),
        .o_frame_address     (o_frame_address),
        .o_frame_length      (o_frame_length),
        .o_body_data         (o_body_data),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_address_enable(i_cfg_address_enable)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ d[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic t_event make_event(input logic [1:0] kind, input logic [6:0] len,
                                          input logic [7:0] data);
        t_event e;
        e.kind = kind;
        e.address = fr_addr;
        e.length = len;
        e.data = data;
        return e;
    endfunction

    task automatic take_header_byte(input logic [7:0] hdr, input logic room,
                                    output logic has_ev, output t_event ev);
        has_ev = 1'b0;
        ev = '0;
        if (!fr_enable[hdr[7]] || !room) begin
            fr_phase = PH_HUNT;
        end else begin
            fr_addr = hdr[7];
            fr_left = hdr[6:0];
            fr_crc = crc8_next(8'h00, hdr);
            fr_phase = PH_MSG;
            has_ev = 1'b1;
            ev = make_event(EV_START, fr_left, 8'h00);
        end
    endtask

    task automatic take_body_byte(input logic [7:0] v, output logic has_ev, output t_event ev);
        has_ev = 1'b0;
        ev = '0;
        fr_crc = crc8_next(fr_crc, v);
        if (fr_left == 7'd0) begin
            fr_phase = PH_END;
        end else begin
            fr_left = fr_left - 7'd1;
            fr_phase = PH_MSG;
            has_ev = 1'b1;
            ev = make_event(EV_BODY, 7'd0, v);
        end
    endtask

    task automatic decode_byte(input logic [7:0] rx, input logic err, input logic room,
                               output logic has_ev, output t_event ev);
        has_ev = 1'b0;
        ev = '0;
        case (fr_phase)
            PH_IDLE: begin
                if (err) begin
                    fr_phase = PH_HUNT;
                end else if (rx == ESC_BYTE) begin
                    fr_phase = PH_IDLE_ESC;
                end else if (rx != FLAG_BYTE) begin
                    take_header_byte(rx, room, has_ev, ev);
                end
            end
            PH_IDLE_ESC: begin
                if (err || rx == ESC_BYTE) begin
                    fr_phase = PH_HUNT;
                end else if (rx == FLAG_BYTE) begin
                    fr_phase = PH_IDLE;
                end else begin
                    take_header_byte(rx ^ ESC_MASK, room, has_ev, ev);
                end
            end
            PH_MSG: begin
                if (err || rx == FLAG_BYTE) begin
                    fr_phase = err ? PH_HUNT : PH_IDLE;
                    has_ev = 1'b1;
                    ev = make_event(EV_ABORT, 7'd0, 8'h00);
                end else if (rx == ESC_BYTE) begin
                    fr_phase = PH_MSG_ESC;
                end else begin
                    take_body_byte(rx, has_ev, ev);
                end
            end
            PH_MSG_ESC: begin
                if (err || rx == ESC_BYTE || rx == FLAG_BYTE) begin
                    fr_phase = (rx == FLAG_BYTE && !err) ? PH_IDLE : PH_HUNT;
                    has_ev = 1'b1;
                    ev = make_event(EV_ABORT, 7'd0, 8'h00);
                end else begin
                    take_body_byte(rx ^ ESC_MASK, has_ev, ev);
                end
            end
            PH_END: begin
                has_ev = 1'b1;
                if (err || rx != FLAG_BYTE) begin
                    fr_phase = PH_HUNT;
                    ev = make_event(EV_ABORT, 7'd0, 8'h00);
                end else begin
                    fr_phase = PH_IDLE;
                    ev = make_event((fr_crc == CRC_GOOD) ? EV_COMMIT : EV_ABORT, 7'd0, 8'h00);
                end
            end
            default: begin
                fr_phase = (!err && rx == FLAG_BYTE) ? PH_IDLE : PH_HUNT;
            end
        endcase
    endtask

    task automatic flag_error(input string msg);
        if (mismatches < 100) begin
            $display("%0t ns error: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic add_row(input logic [7:0] rx, input logic err, input logic room,
                           input logic pinned, input logic some, input logic [1:0] kind,
                           input logic addr, input logic [6:0] len, input logic [7:0] data);
        t_line_item it;
        it.rx = rx;
        it.err = err;
        it.room = room;
        it.pinned = pinned;
        it.pin_some = some;
        it.pin_ev.kind = kind;
        it.pin_ev.address = addr;
        it.pin_ev.length = len;
        it.pin_ev.data = data;
        line_q.push_back(it);
    endtask

    task automatic push_line(input logic [7:0] rx, input logic err, input logic room);
        add_row(rx, err, room, 1'b0, 1'b0, EV_START, 1'b0, 7'd0, 8'h00);
    endtask

    task automatic queue_frame();
        logic [7:0] frame_bytes[$];
        logic [7:0] crc;
        logic [7:0] v;
        logic       room;
        logic       r;
        int         len;
        int         pick;
        int         cut;
        t_fault     fault;
        pick = $urandom_range(99);
        fault = (pick < 70) ? FAULT_NONE : t_fault'($urandom_range(6, 1));
        if ($urandom_range(9) == 0) begin
            push_line(ESC_BYTE, 1'b0, 1'b0);
        end
        repeat ($urandom_range(2, 1)) push_line(FLAG_BYTE, 1'b0, 1'($urandom_range(1)));
        pick = $urandom_range(99);
        len = (pick < 3) ? $urandom_range(127, 100) :
              (pick < 10) ? $urandom_range(40, 9) : $urandom_range(8);
        room = ($urandom_range(9) != 0);
        frame_bytes.push_back({1'($urandom_range(1)), 7'(len)});
        crc = crc8_next(8'h00, frame_bytes[0]);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(9);
            v = (pick == 0) ? FLAG_BYTE : (pick == 1) ? ESC_BYTE :
                (pick == 2) ? (ESC_BYTE ^ ESC_MASK) : 8'($urandom);
            frame_bytes.push_back(v);
            crc = crc8_next(crc, v);
        end
        if (fault == FAULT_BAD_CRC) begin
            crc ^= 8'($urandom_range(255, 1));
        end
        frame_bytes.push_back(crc);
        cut = $urandom_range(frame_bytes.size() - 1);
        for (int i = 0; i < frame_bytes.size(); i++) begin
            if (i == cut && fault == FAULT_LINE_ERR) begin
                push_line(8'($urandom), 1'b1, room);
                break;
            end
            if (i == cut && fault == FAULT_EARLY_FLAG) begin
                break;
            end
            if (i == cut && fault == FAULT_DOUBLE_ESC) begin
                push_line(ESC_BYTE, 1'b0, room);
                push_line(ESC_BYTE, 1'b0, room);
                break;
            end
            v = frame_bytes[i];
            r = (i == 0) ? room : 1'($urandom_range(1));
            // stuff the reserved bytes, and now and then a plain one
            if (v == FLAG_BYTE || v == ESC_BYTE ||
                (v != (FLAG_BYTE ^ ESC_MASK) && v != (ESC_BYTE ^ ESC_MASK) &&
                 $urandom_range(15) == 0)) begin
                push_line(ESC_BYTE, 1'b0, r);
                v ^= ESC_MASK;
            end
            push_line(v, 1'b0, r);
        end
        if (fault == FAULT_TRAILER) begin
            push_line(8'($urandom_range(FLAG_BYTE - 1)), 1'b0, 1'($urandom_range(1)));
        end
        if (fault == FAULT_NOISE) begin
            repeat ($urandom_range(6, 1)) begin
                push_line(8'($urandom), 1'($urandom_range(3) == 0), 1'($urandom_range(1)));
            end
        end
        push_line(FLAG_BYTE, 1'b0, 1'($urandom_range(1)));
    endtask

    task automatic send_lines();
        t_line_item it;
        while (line_q.size() != 0) begin
            it = line_q.pop_front();
            if ($urandom_range(99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
            end
            i_in_valid <= 1'b1;
            i_rx_byte <= it.rx;
            i_line_error <= it.err;
            i_sink_has_room <= it.room;
            drv_item <= it;
            do @(posedge i_clk); while (o_in_stall);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin : monitor
        logic   got;
        t_event ev;
        t_event seen;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                fr_enable = i_cfg_address_enable;
            end
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_rx_byte, i_line_error, i_sink_has_room, got, ev);
                if (drv_item.pinned) begin
                    if (drv_item.pin_some) begin
                        event_q.push_back(drv_item.pin_ev);
                    end
                end else if (got) begin
                    event_q.push_back(ev);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                seen = {o_event_kind, o_frame_address, o_frame_length, o_body_data};
                if (event_q.size() == 0) begin
                    flag_error($sformatf("event kind %0d with none pending", seen.kind));
                end else begin
                    ev = event_q.pop_front();
                    if (seen.kind != ev.kind) begin
                        flag_error($sformatf("kind %0d, wanted %0d", seen.kind, ev.kind));
                    end
                    if (seen.address != ev.address) begin
                        flag_error($sformatf("address %0d, wanted %0d",
                                             seen.address, ev.address));
                    end
                    if (seen.length != ev.length) begin
                        flag_error($sformatf("length %0d, wanted %0d", seen.length, ev.length));
                    end
                    if (seen.data != ev.data) begin
                        flag_error($sformatf("data %02h, wanted %02h", seen.data, ev.data));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int enable_seq[6];
        enable_seq = '{2, 0, 1, 3, 0, 3};
        enable_seq[4] = $urandom_range(3);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        //      byte       err   room  pin   some  kind       addr  len     data
        add_row(FLAG_BYTE, 1'b0, 1'b0, 1'b1, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(ESC_BYTE,  1'b0, 1'b1, 1'b1, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(8'h21,     1'b0, 1'b1, 1'b1, 1'b1, EV_START,  1'b0, 7'd1,   8'h00);
        add_row(ESC_BYTE,  1'b0, 1'b0, 1'b1, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(8'h27,     1'b0, 1'b0, 1'b0, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(8'h00,     1'b0, 1'b0, 1'b0, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(FLAG_BYTE, 1'b0, 1'b0, 1'b0, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(8'hFF,     1'b0, 1'b0, 1'b1, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(FLAG_BYTE, 1'b0, 1'b1, 1'b1, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(8'h82,     1'b0, 1'b1, 1'b1, 1'b1, EV_START,  1'b1, 7'd2,   8'h00);
        add_row(ESC_BYTE,  1'b0, 1'b0, 1'b1, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(8'h5E,     1'b0, 1'b0, 1'b1, 1'b1, EV_BODY,   1'b1, 7'd0,   8'h7E);
        add_row(ESC_BYTE,  1'b0, 1'b0, 1'b1, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(ESC_BYTE,  1'b0, 1'b0, 1'b1, 1'b1, EV_ABORT,  1'b1, 7'd0,   8'h00);
        add_row(FLAG_BYTE, 1'b0, 1'b0, 1'b1, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(8'hFF,     1'b0, 1'b1, 1'b1, 1'b1, EV_START,  1'b1, 7'd127, 8'h00);
        add_row(8'h00,     1'b1, 1'b0, 1'b1, 1'b1, EV_ABORT,  1'b1, 7'd0,   8'h00);
        add_row(FLAG_BYTE, 1'b0, 1'b0, 1'b1, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(8'h7F,     1'b0, 1'b1, 1'b1, 1'b1, EV_START,  1'b0, 7'd127, 8'h00);
        add_row(FLAG_BYTE, 1'b0, 1'b0, 1'b1, 1'b1, EV_ABORT,  1'b0, 7'd0,   8'h00);
        add_row(8'h00,     1'b0, 1'b1, 1'b1, 1'b1, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(8'h55,     1'b0, 1'b0, 1'b0, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(FLAG_BYTE, 1'b0, 1'b0, 1'b1, 1'b1, EV_ABORT,  1'b0, 7'd0,   8'h00);
        add_row(8'h00,     1'b0, 1'b1, 1'b1, 1'b1, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(8'h00,     1'b0, 1'b0, 1'b0, 1'b0, EV_START,  1'b0, 7'd0,   8'h00);
        add_row(8'hAA,     1'b0, 1'b0, 1'b1, 1'b1, EV_ABORT,  1'b0, 7'd0,   8'h00);
        send_lines();

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 62 : 0;
            recv_idle_pct = (ph < 2) ? 62 : (ph < 4) ? 12 : 0;
            wait_quiet();
            i_cfg_valid <= 1'b1;
            i_cfg_address_enable <= 2'(enable_seq[ph]);
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_valid <= 1'b0;
            while (line_q.size() < ITEMS_PER_PHASE) queue_frame();
            send_lines();
        end
        wait_quiet();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/efr_pkg.sv
sv/efr_step.sv
sv/escaped_frame_receiver_crc8.sv
sv/efr_checker.sv
sim/tb_top.sv
